[sv/frame_bitmap_allocator_unit_macros.svh]
// assertion macros for the frame bitmap allocator
// expects clk and rst_n in the scope of use
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define FBA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBA_ASSERT(lbl, ante, cons, msg)
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/fba_pkg.sv]
// shared types and codes for the frame bitmap allocator
// no dependencies
package fba_pkg;

    localparam int ADDR_W = 32;
    localparam int CFG_W  = 11;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 11'd1024;

    // request function codes
    localparam logic [1:0] FUNC_ALLOC     = 2'd0;
    localparam logic [1:0] FUNC_FREE      = 2'd1;
    localparam logic [1:0] FUNC_MARK_USED = 2'd2;
    localparam logic [1:0] FUNC_MARK_FREE = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FRAME  = 2'd1;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_addr;
        logic [1:0]        status;
    } rsp_t;

endpackage

[sv/frame_bitmap_allocator_unit.sv]
// frame bitmap allocator top level: bitmap memory, word walker, result register
// depends on fba_pkg and frame_bitmap_allocator_unit_macros.svh
//
// usage
//   request channel: a request (func, start_addr, end_addr) is taken at a clock
//   edge where start is high and busy is low
//   result channel: done pulses for one cycle with rsp (frame_addr, status);
//   the receiver cannot stall, so the result must be captured in that cycle
//   config: cfg_we writes cfg_data into the usable frame count; only while idle
// timing
//   every request with a non-empty window walks the bitmap one word per cycle
//   from word 0 with a single shared mask/compare unit; the memory read is
//   registered, so a fetch state primes the walk, with busy high throughout
//   allocate: walks words up to and including the first word with a free
//   usable frame (at most WORD_COUNT, 32 by default)
//   free / mark range: walks words up to the range end word
//   empty range, out-of-range free, or no usable frames: busy stays low and
//   done follows in the next cycle
//   done rises the cycle after the last busy cycle
// reset
//   all control state clears, frame count returns to 1024, then a clearing
//   pass writes WORD_COUNT zero words (32 by default) with busy high
`include "frame_bitmap_allocator_unit_macros.svh"

module frame_bitmap_allocator_unit #(
    parameter int MAX_FRAMES = 1024,
    parameter int WORD_BITS  = 32,
    parameter int PAGE_SHIFT = 22
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fba_pkg::req_t               req,
    output logic                        done,
    output fba_pkg::rsp_t               rsp,
    input  logic                        cfg_we,
    input  logic [fba_pkg::CFG_W-1:0]   cfg_data
);

    localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int SPAN       = WORD_COUNT * WORD_BITS;
    localparam int BASE_W     = $clog2(SPAN + 1);
    localparam int OFF_W      = $clog2(WORD_BITS + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int AW         = fba_pkg::ADDR_W;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

    // bits [0, n) set
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [OFF_W-1:0] n);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            m[i] = (OFF_W'(i) < n);
        end
        return m;
    endfunction

    // status for a finished request
    function automatic logic [1:0] status_of(input logic [1:0] fn, input logic hit);
        logic [1:0] s;
        s = fba_pkg::STATUS_OK;
        unique case (fn)
            fba_pkg::FUNC_ALLOC:     s = hit ? fba_pkg::STATUS_OK : fba_pkg::STATUS_NO_FRAME;
            fba_pkg::FUNC_FREE:      s = hit ? fba_pkg::STATUS_OK : fba_pkg::STATUS_NOT_ALLOC;
            fba_pkg::FUNC_MARK_USED: s = fba_pkg::STATUS_OK;
            fba_pkg::FUNC_MARK_FREE: s = fba_pkg::STATUS_OK;
            default:                 s = fba_pkg::STATUS_OK;
        endcase
        return s;
    endfunction

    state_t                   state_reg, state_next;
    logic [fba_pkg::CFG_W-1:0] frame_count_reg;
    logic [WIDX_W-1:0]        cur_reg, cur_next;
    logic [BASE_W-1:0]        base_reg, base_next;
    logic [BASE_W-1:0]        lo_reg, lo_next;
    logic [BASE_W-1:0]        hi_reg, hi_next;
    logic [1:0]               func_reg, func_next;
    logic                     found_reg, found_next;
    logic                     done_reg, done_next;
    fba_pkg::rsp_t            rsp_reg, rsp_next;

    // bitmap memory
    logic [WORD_BITS-1:0]     mem [WORD_COUNT];
    logic [WORD_BITS-1:0]     rdata_reg;
    logic                     mem_we;
    logic [WIDX_W-1:0]        raddr;
    logic [WORD_BITS-1:0]     wdata;

    // request setup, all in 32-bit frame numbers
    logic                     accept;
    logic [AW-1:0]            cnt32, lim32, s32, e32, stop32;
    logic [AW-1:0]            lo32, hi32;

    // shared word unit
    logic [BASE_W-1:0]        lo_d, hi_d;
    logic [OFF_W-1:0]         lo_off, hi_off;
    logic [WORD_BITS-1:0]     word_mask, free_bits, pick, new_word;
    logic [BIT_W-1:0]         pick_idx;
    logic [BASE_W-1:0]        pick_frame;
    logic                     hit_now, more;
    logic [BASE_W:0]          base_step;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // usable limit and request bounds
    always_comb
    begin
        cnt32  = AW'(frame_count_reg);
        lim32  = (cnt32 < AW'(MAX_FRAMES)) ? cnt32 : AW'(MAX_FRAMES);
        s32    = req.start_addr >> PAGE_SHIFT;
        e32    = req.end_addr >> PAGE_SHIFT;
        stop32 = (e32 < lim32) ? e32 : lim32;
        lo32   = '0;
        hi32   = '0;
        unique case (req.func)
            fba_pkg::FUNC_ALLOC:
            begin
                hi32 = lim32;
            end
            fba_pkg::FUNC_FREE:
            begin
                // out-of-range frame leaves an empty window
                if (s32 < lim32)
                begin
                    lo32 = s32;
                    hi32 = s32 + AW'(1);
                end
            end
            default:
            begin
                if (s32 < stop32)
                begin
                    lo32 = s32;
                    hi32 = stop32;
                end
            end
        endcase
    end

    // per-word window, pick and update
    always_comb
    begin
        lo_d = lo_reg - base_reg;
        hi_d = hi_reg - base_reg;
        if (lo_reg <= base_reg)
            lo_off = '0;
        else if (lo_d >= BASE_W'(WORD_BITS))
            lo_off = OFF_W'(WORD_BITS);
        else
            lo_off = lo_d[OFF_W-1:0];
        if (hi_reg <= base_reg)
            hi_off = '0;
        else if (hi_d >= BASE_W'(WORD_BITS))
            hi_off = OFF_W'(WORD_BITS);
        else
            hi_off = hi_d[OFF_W-1:0];

        word_mask = low_mask(hi_off) & ~low_mask(lo_off);
        free_bits = ~rdata_reg & word_mask;
        pick      = free_bits & (~free_bits + WORD_BITS'(1));

        pick_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (pick[i])
                pick_idx = pick_idx | BIT_W'(i);
        end
        pick_frame = base_reg + BASE_W'(pick_idx);

        hit_now  = 1'b0;
        new_word = rdata_reg;
        unique case (func_reg)
            fba_pkg::FUNC_ALLOC:
            begin
                hit_now  = |free_bits;
                new_word = rdata_reg | pick;
            end
            fba_pkg::FUNC_FREE:
            begin
                hit_now  = |(rdata_reg & word_mask);
                new_word = rdata_reg & ~word_mask;
            end
            fba_pkg::FUNC_MARK_USED:
            begin
                new_word = rdata_reg | word_mask;
            end
            fba_pkg::FUNC_MARK_FREE:
            begin
                new_word = rdata_reg & ~word_mask;
            end
            default:
            begin
                new_word = rdata_reg;
            end
        endcase

        base_step = {1'b0, base_reg} + (BASE_W+1)'(WORD_BITS);
        // walk on while the window reaches past this word, stop at the first grant
        more = (base_step < {1'b0, hi_reg}) &&
               !((func_reg == fba_pkg::FUNC_ALLOC) && hit_now);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        base_next  = base_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        func_next  = func_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        wdata      = new_word;
        raddr      = cur_reg + WIDX_W'(1);

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                wdata  = '0;
                if (cur_reg == WIDX_W'(WORD_COUNT - 1))
                begin
                    cur_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + WIDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next  = req.func;
                    lo_next    = lo32[BASE_W-1:0];
                    hi_next    = hi32[BASE_W-1:0];
                    cur_next   = '0;
                    base_next  = '0;
                    found_next = 1'b0;
                    if (hi32 == '0)
                    begin
                        // nothing to walk: answer at once
                        done_next           = 1'b1;
                        rsp_next.frame_addr = '0;
                        rsp_next.status     = status_of(req.func, 1'b0);
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                raddr      = cur_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                mem_we     = 1'b1;
                found_next = found_reg | hit_now;
                if (more)
                begin
                    cur_next  = cur_reg + WIDX_W'(1);
                    base_next = base_step[BASE_W-1:0];
                end
                else
                begin
                    state_next      = ST_IDLE;
                    done_next       = 1'b1;
                    rsp_next.status = status_of(func_reg, found_reg | hit_now);
                    if ((func_reg == fba_pkg::FUNC_ALLOC) && hit_now)
                        rsp_next.frame_addr = AW'(pick_frame) << PAGE_SHIFT;
                    else
                        rsp_next.frame_addr = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            frame_count_reg <= fba_pkg::FRAME_COUNT_RESET;
            cur_reg         <= '0;
            base_reg        <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            func_reg        <= fba_pkg::FUNC_ALLOC;
            found_reg       <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                frame_count_reg <= cfg_data;
            cur_reg   <= cur_next;
            base_reg  <= base_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            func_reg  <= func_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // bitmap memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[cur_reg] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // checks
    `FBA_ASSERT(a_done_cause, done_reg, ($past(state_reg == ST_SCAN) || $past(accept)), "done without a finished request")
    `FBA_ASSERT(a_fail_no_addr, (done_reg && (rsp_reg.status != fba_pkg::STATUS_OK)), (rsp_reg.frame_addr == '0), "failed request returned an address")
    `FBA_ASSERT(a_scan_in_range, (state_reg == ST_SCAN), (cur_reg <= WIDX_W'(WORD_COUNT - 1)), "walk beyond bitmap end")
    `FBA_ASSERT_NEXT(a_scan_busy, (state_reg == ST_FETCH), (state_reg == ST_SCAN), "fetch not followed by scan")

endmodule
